// ===== design/ciua_pkg.sv =====
// shared types, opcodes and sequencer states of the checked int64 update alu
package ciua_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = 6;
    localparam int TYPE_W = 4;

    localparam logic [DATA_W-1:0] MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [TYPE_W-1:0] {
        OP_SET = 4'd0,
        OP_MAX = 4'd1,
        OP_MIN = 4'd2,
        OP_ADD = 4'd3,
        OP_SUB = 4'd4,
        OP_MUL = 4'd5,
        OP_DIV = 4'd6,
        OP_MOD = 4'd7,
        OP_AND = 4'd8,
        OP_OR  = 4'd9,
        OP_XOR = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_NEG_A,
        ST_NEG_B,
        ST_ITER,
        ST_FIX,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [DATA_W-1:0] operand;
        logic              first;
        logic [DATA_W-1:0] prior_value;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] updated_value;
        logic              ok;
    } result_t;

endpackage

// ===== design/ciua_addsub.sv =====
// shared 64-bit adder/subtractor with carry out
module ciua_addsub
    import ciua_pkg::*;
(
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic              sub,
    output logic [DATA_W-1:0] sum,
    output logic              cout
);

    logic [DATA_W:0] wide;

    // subtract as a + ~b + 1; cout high means no borrow
    assign wide = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{DATA_W{1'b0}}, sub};
    assign sum  = wide[DATA_W-1:0];
    assign cout = wide[DATA_W];

endmodule

// ===== design/ciua_core.sv =====
// sequencer and datapath registers driving the shared adder
module ciua_core
    import ciua_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    res_valid,
    input  logic    res_room,
    output result_t res
);

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              failed_reg, failed_next;
    op_t               op_reg, op_next;
    logic              bad_op_reg, bad_op_next;
    logic [DATA_W-1:0] opnd_reg, opnd_next;
    logic              last_reg, last_next;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [DATA_W-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [DATA_W-1:0] add_a, add_b, add_sum;
    logic              add_sub, add_cout;

    logic              is_mul;
    logic              ovf;
    logic              less_ab;
    logic              neg_res;
    logic              mul_ovf;
    logic [DATA_W-1:0] rem_shift;
    logic [DATA_W-1:0] fix_mag;

    ciua_addsub u_addsub (
        .a    (add_a),
        .b    (add_b),
        .sub  (add_sub),
        .sum  (add_sum),
        .cout (add_cout)
    );

    assign is_mul    = (op_reg == OP_MUL);
    assign rem_shift = {hi_reg[DATA_W-2:0], lo_reg[DATA_W-1]};
    assign fix_mag   = (op_reg == OP_MOD) ? hi_reg : lo_reg;
    assign neg_res   = (op_reg == OP_MOD) ? acc_reg[DATA_W-1]
                                          : (acc_reg[DATA_W-1] ^ opnd_reg[DATA_W-1]);
    // product magnitude must fit 2^63 when negative, 2^63-1 otherwise
    assign mul_ovf   = (hi_reg != '0) ||
                       (neg_res ? (lo_reg[DATA_W-1] && (lo_reg[DATA_W-2:0] != '0))
                                : lo_reg[DATA_W-1]);

    // signed overflow of the exec-cycle add or subtract
    always_comb begin
        if (op_reg == OP_ADD) begin
            ovf = (acc_reg[DATA_W-1] ^ add_sum[DATA_W-1]) &
                  (opnd_reg[DATA_W-1] ^ add_sum[DATA_W-1]);
        end else begin
            ovf = (acc_reg[DATA_W-1] ^ opnd_reg[DATA_W-1]) &
                  (acc_reg[DATA_W-1] ^ add_sum[DATA_W-1]);
        end
    end
    assign less_ab = add_sum[DATA_W-1] ^ ovf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            acc_reg    <= '0;
            failed_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            failed_reg <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        bad_op_reg <= bad_op_next;
        opnd_reg   <= opnd_next;
        last_reg   <= last_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        mag_reg    <= mag_next;
        cnt_reg    <= cnt_next;
    end

    always_comb begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        failed_next = failed_reg;
        op_next     = op_reg;
        bad_op_next = bad_op_reg;
        opnd_next   = opnd_reg;
        last_next   = last_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        mag_next    = mag_reg;
        cnt_next    = cnt_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        add_a       = acc_reg;
        add_b       = opnd_reg;
        add_sub     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next     = op_t'(in_item.req_type);
                    bad_op_next = (in_item.req_type > TYPE_W'(OP_XOR));
                    opnd_next   = in_item.operand;
                    last_next   = in_item.last;
                    if (in_item.first) begin
                        acc_next    = in_item.prior_value;
                        failed_next = 1'b0;
                    end
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                add_sub    = (op_reg != OP_ADD);
                state_next = ST_FINISH;
                if (!failed_reg) begin
                    if (bad_op_reg) begin
                        failed_next = 1'b1;
                    end else begin
                        unique case (op_reg)
                            OP_SET: acc_next = opnd_reg;
                            OP_MAX: acc_next = less_ab ? opnd_reg : acc_reg;
                            OP_MIN: acc_next = (!less_ab && (acc_reg != opnd_reg))
                                               ? opnd_reg : acc_reg;
                            OP_ADD, OP_SUB: begin
                                if (ovf) begin
                                    failed_next = 1'b1;
                                end else begin
                                    acc_next = add_sum;
                                end
                            end
                            OP_MUL: state_next = ST_NEG_A;
                            OP_DIV, OP_MOD: begin
                                if ((opnd_reg == '0) ||
                                    ((acc_reg == MIN_VALUE) && (opnd_reg == '1))) begin
                                    failed_next = 1'b1;
                                end else begin
                                    state_next = ST_NEG_A;
                                end
                            end
                            OP_AND: acc_next = acc_reg & opnd_reg;
                            OP_OR:  acc_next = acc_reg | opnd_reg;
                            OP_XOR: acc_next = acc_reg ^ opnd_reg;
                            default: failed_next = 1'b1;
                        endcase
                    end
                end
            end

            ST_NEG_A: begin
                // multiplicand for mul, dividend for div and mod
                add_a   = '0;
                add_b   = acc_reg;
                add_sub = 1'b1;
                if (is_mul) begin
                    mag_next = acc_reg[DATA_W-1] ? add_sum : acc_reg;
                end else begin
                    lo_next = acc_reg[DATA_W-1] ? add_sum : acc_reg;
                end
                state_next = ST_NEG_B;
            end

            ST_NEG_B: begin
                add_a   = '0;
                add_b   = opnd_reg;
                add_sub = 1'b1;
                if (is_mul) begin
                    lo_next = opnd_reg[DATA_W-1] ? add_sum : opnd_reg;
                end else begin
                    mag_next = opnd_reg[DATA_W-1] ? add_sum : opnd_reg;
                end
                hi_next    = '0;
                cnt_next   = '0;
                state_next = ST_ITER;
            end

            ST_ITER: begin
                if (is_mul) begin
                    // shift-add, multiplier bits leave lo as product bits enter
                    add_a   = hi_reg;
                    add_b   = mag_reg;
                    add_sub = 1'b0;
                    if (lo_reg[0]) begin
                        hi_next = {add_cout, add_sum[DATA_W-1:1]};
                        lo_next = {add_sum[0], lo_reg[DATA_W-1:1]};
                    end else begin
                        hi_next = {1'b0, hi_reg[DATA_W-1:1]};
                        lo_next = {hi_reg[0], lo_reg[DATA_W-1:1]};
                    end
                end else begin
                    // restoring division, quotient bits shift into lo
                    add_a   = rem_shift;
                    add_b   = mag_reg;
                    add_sub = 1'b1;
                    hi_next = add_cout ? add_sum : rem_shift;
                    lo_next = {lo_reg[DATA_W-2:0], add_cout};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == '1) begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX: begin
                add_a   = '0;
                add_b   = fix_mag;
                add_sub = 1'b1;
                if (is_mul && mul_ovf) begin
                    failed_next = 1'b1;
                end else begin
                    acc_next = neg_res ? add_sum : fix_mag;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (res_room) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign res.updated_value = failed_reg ? '0 : acc_reg;
    assign res.ok            = !failed_reg;

endmodule

// ===== design/checked_int64_update_alu_unit.sv =====
// top level: input handshake, sequencer core and registered result channel

// Applies runs of checked 64-bit update operations (set, max, min, add, sub,
// mul, div, mod, and, or, xor) to one signed accumulator and returns the value
// with an ok flag after the item marked last. One item is worked on at a time
// and s_ready is high only while the sequencer is idle. Set, max, min, add,
// sub, the bitwise operations, unknown operations and divides rejected for a
// zero or overflowing divisor go from transfer to the next possible transfer
// through decode, finish and idle. Mul, div and mod pass through decode, two
// steps to form operand magnitudes, 64 shift-add or restore-subtract passes
// through the one shared 64-bit adder, one step to apply the result sign,
// then finish and idle. The result sits in an output register, so the next
// item can be taken while it waits; the sequencer only holds when a second
// result is ready and the first has not been taken.
module checked_int64_update_alu_unit
    import ciua_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [TYPE_W-1:0]        s_req_type,
    input  logic signed [DATA_W-1:0] s_operand,
    input  logic                     s_first,
    input  logic signed [DATA_W-1:0] s_prior_value,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_updated_value,
    output logic                     m_ok
);

    item_t             item;
    result_t           res;
    logic              res_valid;
    logic              res_room;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;
    logic              m_ok_reg, m_ok_next;

    assign item.req_type    = s_req_type;
    assign item.operand     = s_operand;
    assign item.first       = s_first;
    assign item.prior_value = s_prior_value;
    assign item.last        = s_last;

    // output slot is free when empty or drained this cycle
    assign res_room = !m_valid_reg || m_ready;

    ciua_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (item),
        .res_valid (res_valid),
        .res_room  (res_room),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_ok_next    = m_ok_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_value_next = res.updated_value;
            m_ok_next    = res.ok;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_ok_reg    <= m_ok_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_updated_value = m_value_reg;
    assign m_ok            = m_ok_reg;

endmodule

// ===== design/ciua_checker.sv =====
// port-level checks of the checked int64 update alu, bound to the top level
module ciua_checker
    import ciua_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_updated_value,
    input logic                     m_ok
);

    // a held result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_updated_value) && $stable(m_ok))
        else $error("result changed while stalled");

    // a failed run reports zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_updated_value == '0)
        else $error("failed run with nonzero value");

    // one item at a time: no transfer in the cycle after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // reset empties the result channel
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind checked_int64_update_alu_unit ciua_checker u_ciua_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_updated_value (m_updated_value),
    .m_ok            (m_ok)
);
